// ----- hw/rtl/vstr_pkg.sv -----
// vstr_pkg: types, codes and saturating arithmetic helpers for the vertex
// scale/translate/rotate pipeline. no dependencies.
package vstr_pkg;

  typedef enum logic [1:0] {
    MODE_SCALE     = 2'd0,
    MODE_TRANSLATE = 2'd1,
    MODE_ROTATE    = 2'd2,
    MODE_PASS      = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    REG_MODE   = 3'd0,
    REG_COEF_A = 3'd1,
    REG_COEF_B = 3'd2,
    REG_COEF_C = 3'd3,
    REG_SINE_A = 3'd4,
    REG_SINE_B = 3'd5,
    REG_SINE_C = 3'd6,
    REG_NONE   = 3'd7
  } reg_idx_t;

  localparam int unsigned CoordW = 32;
  localparam int unsigned SineW  = 18;
  localparam int unsigned ProdW  = 2 * CoordW;
  localparam int unsigned FracW  = 16;

  typedef struct packed {
    logic signed [CoordW-1:0] v;
    logic                     clip;
  } sat_t;

  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] z;
  } vec_t;

  // (p +/- q) >>> 16, saturated to 32 bits
  function automatic sat_t mac_sat(input logic signed [ProdW-1:0] p,
                                   input logic signed [ProdW-1:0] q,
                                   input logic sub);
    logic signed [ProdW-1:0]       s;
    logic signed [ProdW-FracW-1:0] sh;
    sat_t                          r;
    s  = sub ? (p - q) : (p + q);
    sh = s[ProdW-1:FracW];
    if ((&sh[ProdW-FracW-1:CoordW-1]) || !(|sh[ProdW-FracW-1:CoordW-1])) begin
      r.v    = sh[CoordW-1:0];
      r.clip = 1'b0;
    end else begin
      r.v    = sh[ProdW-FracW-1] ? {1'b1, {(CoordW-1){1'b0}}} : {1'b0, {(CoordW-1){1'b1}}};
      r.clip = 1'b1;
    end
    return r;
  endfunction

  // a + b, saturated to 32 bits
  function automatic sat_t add_sat(input logic signed [CoordW-1:0] a,
                                   input logic signed [CoordW-1:0] b);
    logic signed [CoordW:0] s;
    sat_t                   r;
    s = {a[CoordW-1], a} + {b[CoordW-1], b};
    if (s[CoordW] == s[CoordW-1]) begin
      r.v    = s[CoordW-1:0];
      r.clip = 1'b0;
    end else begin
      r.v    = s[CoordW] ? {1'b1, {(CoordW-1){1'b0}}} : {1'b0, {(CoordW-1){1'b1}}};
      r.clip = 1'b1;
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/vertex_scale_translate_rotate_unit.sv -----
// vertex_scale_translate_rotate_unit: six-stage vertex transform pipeline
// with apb register file. depends on vstr_pkg.
//
// channel   direction  handshake               payload
// input     in         start (busy always low) pos_x pos_y pos_z final_in
// result    out        done, one cycle         out_x out_y out_z clipped final_out
// config    in/out     apb psel/penable/pwrite paddr pwdata prdata pready
//
// one vertex may enter every cycle; each result passes all six registered stages,
// s1 to s6, which hold the three multiply/accumulate stage pairs of the rotate path.
// rst is synchronous and clears the registers to their defaults and all
// pipeline valid bits. the receiver cannot stall, so the pipeline never holds.
module vertex_scale_translate_rotate_unit (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  logic signed [vstr_pkg::CoordW-1:0]    pos_x,
  input  logic signed [vstr_pkg::CoordW-1:0]    pos_y,
  input  logic signed [vstr_pkg::CoordW-1:0]    pos_z,
  input  logic                                  final_in,
  output logic                                  done,
  output logic signed [vstr_pkg::CoordW-1:0]    out_x,
  output logic signed [vstr_pkg::CoordW-1:0]    out_y,
  output logic signed [vstr_pkg::CoordW-1:0]    out_z,
  output logic                                  clipped,
  output logic                                  final_out,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [4:0]                            paddr,
  input  logic [31:0]                           pwdata,
  output logic [31:0]                           prdata,
  output logic                                  pready
);
  import vstr_pkg::*;

  // register file
  mode_t                    mode;
  logic signed [CoordW-1:0] coef_a, coef_b, coef_c;
  logic signed [SineW-1:0]  sine_a, sine_b, sine_c;
  logic signed [CoordW-1:0] sa, sb, sc;
  reg_idx_t                 ridx;
  logic                     wr_en;

  assign pready = 1'b1;
  assign ridx   = reg_idx_t'(paddr[4:2]);
  assign wr_en  = psel && penable && pwrite && pready;
  assign sa     = {{(CoordW-SineW){sine_a[SineW-1]}}, sine_a};
  assign sb     = {{(CoordW-SineW){sine_b[SineW-1]}}, sine_b};
  assign sc     = {{(CoordW-SineW){sine_c[SineW-1]}}, sine_c};

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= MODE_SCALE;
      coef_a <= 32'sd65536;
      coef_b <= 32'sd65536;
      coef_c <= 32'sd65536;
      sine_a <= '0;
      sine_b <= '0;
      sine_c <= '0;
    end else if (wr_en) begin
      unique case (ridx)
        REG_MODE:   mode   <= mode_t'(pwdata[1:0]);
        REG_COEF_A: coef_a <= pwdata;
        REG_COEF_B: coef_b <= pwdata;
        REG_COEF_C: coef_c <= pwdata;
        REG_SINE_A: sine_a <= pwdata[SineW-1:0];
        REG_SINE_B: sine_b <= pwdata[SineW-1:0];
        REG_SINE_C: sine_c <= pwdata[SineW-1:0];
        REG_NONE:   ;
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      REG_MODE:   prdata = {30'd0, mode};
      REG_COEF_A: prdata = coef_a;
      REG_COEF_B: prdata = coef_b;
      REG_COEF_C: prdata = coef_c;
      REG_SINE_A: prdata = sa;
      REG_SINE_B: prdata = sb;
      REG_SINE_C: prdata = sc;
      REG_NONE:   prdata = '0;
    endcase
  end

  assign busy = 1'b0;

  // pipeline registers
  logic                     s1_valid, s2_valid, s3_valid, s4_valid, s5_valid, s6_valid;
  mode_t                    s1_mode, s2_mode, s3_mode, s4_mode, s5_mode;
  logic                     s1_final, s2_final, s3_final, s4_final, s5_final, s6_final;
  logic                     s1_clip, s2_clip, s3_clip, s4_clip, s5_clip, s6_clip;
  vec_t                     s1_v, s2_v, s3_v, s4_v, s5_v, s6_v;
  logic signed [ProdW-1:0]  s1_p0, s1_p1, s1_p2, s1_p3;
  logic signed [ProdW-1:0]  s3_p0, s3_p1, s3_p2, s3_p3;
  logic signed [ProdW-1:0]  s5_p0, s5_p1, s5_p2, s5_p3;

  // stage 1 operands
  logic signed [CoordW-1:0] m0a, m0b, m1a, m1b, m2a, m2b, m3a, m3b;
  vec_t                     v1_next;
  logic                     c1_next;
  sat_t                     tx, ty, tz;

  assign tx = add_sat(pos_x, coef_a);
  assign ty = add_sat(pos_y, coef_b);
  assign tz = add_sat(pos_z, coef_c);

  always_comb begin
    m0a = pos_x;  m0b = coef_a;
    m1a = pos_y;  m1b = coef_b;
    m2a = pos_z;  m2b = coef_c;
    m3a = '0;     m3b = '0;
    v1_next = '{x: pos_x, y: pos_y, z: pos_z};
    c1_next = 1'b0;
    unique case (mode)
      MODE_SCALE: ;
      MODE_TRANSLATE: begin
        v1_next = '{x: tx.v, y: ty.v, z: tz.v};
        c1_next = tx.clip | ty.clip | tz.clip;
      end
      MODE_ROTATE: begin
        m0a = pos_x;  m0b = coef_c;
        m1a = pos_y;  m1b = sc;
        m2a = pos_x;  m2b = sc;
        m3a = pos_y;  m3b = coef_c;
      end
      MODE_PASS: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= start && !busy;
    end
    s1_mode  <= mode;
    s1_final <= final_in;
    s1_clip  <= c1_next;
    s1_v     <= v1_next;
    s1_p0    <= m0a * m0b;
    s1_p1    <= m1a * m1b;
    s1_p2    <= m2a * m2b;
    s1_p3    <= m3a * m3b;
  end

  // stage 2: scale results or rotation about z
  sat_t r2a, r2b, r2c, r2d, r2e;
  vec_t v2_next;
  logic c2_next;

  assign r2a = mac_sat(s1_p0, '0, 1'b0);
  assign r2b = mac_sat(s1_p1, '0, 1'b0);
  assign r2c = mac_sat(s1_p2, '0, 1'b0);
  assign r2d = mac_sat(s1_p0, s1_p1, 1'b1);
  assign r2e = mac_sat(s1_p2, s1_p3, 1'b0);

  always_comb begin
    v2_next = s1_v;
    c2_next = s1_clip;
    unique case (s1_mode)
      MODE_SCALE: begin
        v2_next = '{x: r2a.v, y: r2b.v, z: r2c.v};
        c2_next = r2a.clip | r2b.clip | r2c.clip;
      end
      MODE_ROTATE: begin
        v2_next.x = r2d.v;
        v2_next.y = r2e.v;
        c2_next   = r2d.clip | r2e.clip;
      end
      MODE_TRANSLATE, MODE_PASS: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
    s2_mode  <= s1_mode;
    s2_final <= s1_final;
    s2_clip  <= c2_next;
    s2_v     <= v2_next;
  end

  // stage 3: products for rotation about y
  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= s2_valid;
    end
    s3_mode  <= s2_mode;
    s3_final <= s2_final;
    s3_clip  <= s2_clip;
    s3_v     <= s2_v;
    s3_p0    <= s2_v.x * coef_b;
    s3_p1    <= s2_v.z * sb;
    s3_p2    <= s2_v.z * coef_b;
    s3_p3    <= s2_v.x * sb;
  end

  // stage 4: rotation about y
  sat_t r4x, r4z;
  vec_t v4_next;
  logic c4_next;

  assign r4x = mac_sat(s3_p0, s3_p1, 1'b0);
  assign r4z = mac_sat(s3_p2, s3_p3, 1'b1);

  always_comb begin
    v4_next = s3_v;
    c4_next = s3_clip;
    if (s3_mode == MODE_ROTATE) begin
      v4_next.x = r4x.v;
      v4_next.z = r4z.v;
      c4_next   = s3_clip | r4x.clip | r4z.clip;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else begin
      s4_valid <= s3_valid;
    end
    s4_mode  <= s3_mode;
    s4_final <= s3_final;
    s4_clip  <= c4_next;
    s4_v     <= v4_next;
  end

  // stage 5: products for rotation about x
  always_ff @(posedge clk) begin
    if (rst) begin
      s5_valid <= 1'b0;
    end else begin
      s5_valid <= s4_valid;
    end
    s5_mode  <= s4_mode;
    s5_final <= s4_final;
    s5_clip  <= s4_clip;
    s5_v     <= s4_v;
    s5_p0    <= s4_v.y * coef_a;
    s5_p1    <= s4_v.z * sa;
    s5_p2    <= s4_v.y * sa;
    s5_p3    <= s4_v.z * coef_a;
  end

  // stage 6: rotation about x, result register
  sat_t r6y, r6z;
  vec_t v6_next;
  logic c6_next;

  assign r6y = mac_sat(s5_p0, s5_p1, 1'b1);
  assign r6z = mac_sat(s5_p2, s5_p3, 1'b0);

  always_comb begin
    v6_next = s5_v;
    c6_next = s5_clip;
    if (s5_mode == MODE_ROTATE) begin
      v6_next.y = r6y.v;
      v6_next.z = r6z.v;
      c6_next   = s5_clip | r6y.clip | r6z.clip;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_valid <= 1'b0;
    end else begin
      s6_valid <= s5_valid;
    end
    s6_final <= s5_final;
    s6_clip  <= c6_next;
    s6_v     <= v6_next;
  end

  assign done      = s6_valid;
  assign out_x     = s6_v.x;
  assign out_y     = s6_v.y;
  assign out_z     = s6_v.z;
  assign clipped   = s6_clip;
  assign final_out = s6_final;

endmodule
